### rtl/chtab_pkg.sv
// Shared codes and controller/datapath handshake types for the chained hash table.
package chtab_pkg;

  localparam logic [2:0] OP_PUT    = 3'd0;
  localparam logic [2:0] OP_GET    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_EXISTS = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOKEY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int          CFG_BITS  = 7;
  localparam logic [6:0]  CFG_RESET = 7'd64;

  typedef struct packed {
    logic load;
    logic div_step;
    logic head_rd;
    logic head_take;
    logic node_rd;
    logic node_adv;
    logic act;
    logic link;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       walk_end;
    logic       key_match;
    logic       hit;
    logic       can_alloc;
    logic [2:0] op;
  } sts_t;

endpackage

### rtl/chtab_ctrl.sv
// Sequencer for one request: hash, head read, chain walk, update, result.
module chtab_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        in_op,
  output logic              busy,
  output chtab_pkg::cmd_t   cmd,
  input  chtab_pkg::sts_t   sts
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DIV  = 9'b000000010,
    S_HRD  = 9'b000000100,
    S_HTK  = 9'b000001000,
    S_CHK  = 9'b000010000,
    S_NWT  = 9'b000100000,
    S_ACT  = 9'b001000000,
    S_LNK  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_op inside {[chtab_pkg::OP_CLEAR:3'd7]}) state_nxt = S_DONE;
          else                                           state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_HRD;
        else              cmd.div_step = 1'b1;
      end
      S_HRD: begin
        cmd.head_rd = 1'b1;
        state_nxt   = S_HTK;
      end
      S_HTK: begin
        cmd.head_take = 1'b1;
        state_nxt     = S_CHK;
      end
      S_CHK: begin
        if (sts.walk_end) begin
          state_nxt = S_ACT;
        end else begin
          cmd.node_rd = 1'b1;
          state_nxt   = S_NWT;
        end
      end
      S_NWT: begin
        cmd.node_adv = 1'b1;
        state_nxt    = sts.key_match ? S_ACT : S_CHK;
      end
      S_ACT: begin
        cmd.act = 1'b1;
        // new key: node written now, linked into its chain next cycle
        if (sts.op == chtab_pkg::OP_PUT && !sts.hit && sts.can_alloc) state_nxt = S_LNK;
        else                                                           state_nxt = S_DONE;
      end
      S_LNK: begin
        cmd.link  = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

### rtl/chtab_dp.sv
// Datapath: divider, bucket heads, node pool, free stack and result registers.
module chtab_dp #(
  parameter int NUM_BUCKETS = 64,
  parameter int POOL_SIZE   = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  chtab_pkg::cmd_t   cmd,
  output chtab_pkg::sts_t   sts,
  input  logic [2:0]        in_op,
  input  logic [31:0]       in_key,
  input  logic [31:0]       in_value,
  input  logic              cfg_we,
  input  logic [6:0]        cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_status,
  output logic [31:0]       out_found_value,
  output logic [8:0]        out_entry_count
);

  localparam int NW  = $clog2(POOL_SIZE + 1);
  localparam int NAW = $clog2(POOL_SIZE);
  localparam int BAW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int RW  = $clog2(NUM_BUCKETS + 1);
  localparam int KCW = $clog2(KEY_BITS + 1);
  localparam logic [NW-1:0] NIL = NW'(POOL_SIZE);

  // configuration
  logic [6:0] cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      cfg_r <= chtab_pkg::CFG_RESET;
    else if (cfg_we) cfg_r <= cfg_wdata;
  end

  logic [31:0]   cfg_w;
  logic [RW-1:0] n_load;
  assign cfg_w  = 32'(cfg_r);
  assign n_load = (cfg_r == 7'd0) ? RW'(1) :
                  (cfg_w > 32'(NUM_BUCKETS)) ? RW'(NUM_BUCKETS) : RW'(cfg_w);

  // request registers and restoring divider (one key bit per cycle)
  logic [2:0]            op_r;
  logic [KEY_BITS-1:0]   key_r, kq_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [RW-1:0]         n_r, rem_r;
  logic [KCW-1:0]        div_cnt_r;
  logic [RW:0]           trial;
  logic                  trial_ge;

  assign trial    = {rem_r, kq_r[KEY_BITS-1]};
  assign trial_ge = (trial >= {1'b0, n_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      key_r     <= KEY_BITS'(in_key);
      kq_r      <= KEY_BITS'(in_key);
      val_r     <= VALUE_BITS'(in_value);
      n_r       <= n_load;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      kq_r      <= kq_r << 1;
      rem_r     <= trial_ge ? RW'(trial - {1'b0, n_r}) : trial[RW-1:0];
      div_cnt_r <= div_cnt_r + KCW'(1);
    end
  end

  logic [BAW-1:0] bidx;
  assign bidx = BAW'(rem_r);

  // stored count and free-stack high-water mark; slots below the mark were pushed
  logic [NW-1:0] stored_r, hw_r, stored_m1;
  logic          do_alloc, do_free;
  assign stored_m1 = stored_r - NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stored_r <= '0;
      hw_r     <= '0;
    end else if (cmd.load && in_op == chtab_pkg::OP_CLEAR) begin
      stored_r <= '0;
      hw_r     <= '0;
    end else if (do_alloc) begin
      stored_r <= stored_r + NW'(1);
      if (hw_r <= stored_r) hw_r <= stored_r + NW'(1);
    end else if (do_free) begin
      stored_r <= stored_m1;
    end
  end

  // bucket heads: memory plus one valid flop per bucket
  logic [NW-1:0]  head_mem [NUM_BUCKETS];
  logic           head_vld_r [NUM_BUCKETS];
  logic [NW-1:0]  head_q_r;
  logic           head_v_q_r;
  logic           head_we;
  logic [NW-1:0]  head_wd;

  always_ff @(posedge clk) begin
    if (head_we) head_mem[bidx] <= head_wd;
    if (cmd.head_rd) begin
      head_q_r   <= head_mem[bidx];
      head_v_q_r <= head_vld_r[bidx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.load && in_op == chtab_pkg::OP_CLEAR)) begin
      for (int i = 0; i < NUM_BUCKETS; i++) head_vld_r[i] <= 1'b0;
    end else if (head_we) begin
      head_vld_r[bidx] <= 1'b1;
    end
  end

  // free stack
  logic [NAW-1:0] fs_mem [POOL_SIZE];
  logic [NAW-1:0] fs_q_r;
  logic           fs_old_q_r;
  logic [NAW-1:0] pop_slot, push_slot;
  assign pop_slot  = NAW'(POOL_SIZE - 1) - stored_r[NAW-1:0];
  assign push_slot = NAW'(POOL_SIZE - 1) - stored_m1[NAW-1:0];

  logic [NW-1:0] node_r;
  always_ff @(posedge clk) begin
    if (do_free) fs_mem[push_slot] <= NAW'(node_r);
    if (cmd.head_rd) begin
      fs_q_r     <= fs_mem[pop_slot];
      fs_old_q_r <= (stored_r < hw_r);
    end
  end

  // node pool
  logic [KEY_BITS-1:0]   nkey_mem [POOL_SIZE];
  logic [VALUE_BITS-1:0] nval_mem [POOL_SIZE];
  logic [NW-1:0]         nnext_mem [POOL_SIZE];
  logic [KEY_BITS-1:0]   nk_q_r;
  logic [VALUE_BITS-1:0] nv_q_r;
  logic [NW-1:0]         nn_q_r;

  logic [NW-1:0] cur_r, before_r, prev_r, tail_r, steps_r, fresh_r;
  logic          hit_r;
  logic          nkey_we, nval_we, nnext_we;
  logic [NW-1:0] nval_wa, nnext_wa, nnext_wd;

  always_ff @(posedge clk) begin
    if (nkey_we)  nkey_mem[NAW'(fresh_r)]   <= key_r;
    if (nval_we)  nval_mem[NAW'(nval_wa)]   <= val_r;
    if (nnext_we) nnext_mem[NAW'(nnext_wa)] <= nnext_wd;
    if (cmd.node_rd) begin
      nk_q_r <= nkey_mem[NAW'(cur_r)];
      nv_q_r <= nval_mem[NAW'(cur_r)];
      nn_q_r <= nnext_mem[NAW'(cur_r)];
    end
  end

  // chain walk
  logic [VALUE_BITS-1:0] found_r;
  logic                  key_match;
  assign key_match = (nk_q_r == key_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      found_r <= '0;
      hit_r   <= 1'b0;
    end else if (cmd.head_take) begin
      cur_r    <= head_v_q_r ? head_q_r : NIL;
      before_r <= NIL;
      tail_r   <= NIL;
      steps_r  <= '0;
      hit_r    <= 1'b0;
      fresh_r  <= fs_old_q_r ? NW'(fs_q_r) : stored_r;
    end else if (cmd.node_adv) begin
      if (key_match) begin
        hit_r  <= 1'b1;
        node_r <= cur_r;
        prev_r <= before_r;
        if (op_r == chtab_pkg::OP_GET) found_r <= nv_q_r;
      end else begin
        tail_r   <= cur_r;
        before_r <= cur_r;
        cur_r    <= nn_q_r;
        steps_r  <= steps_r + NW'(1);
      end
    end
  end

  // updates
  logic can_alloc;
  assign can_alloc = (stored_r != NIL);

  always_comb begin
    do_alloc = 1'b0;
    do_free  = 1'b0;
    nkey_we  = 1'b0;
    nval_we  = 1'b0;
    nnext_we = 1'b0;
    nval_wa  = fresh_r;
    nnext_wa = fresh_r;
    nnext_wd = NIL;
    head_we  = 1'b0;
    head_wd  = fresh_r;
    if (cmd.act) begin
      if (op_r == chtab_pkg::OP_PUT) begin
        if (hit_r) begin
          nval_we = 1'b1;
          nval_wa = node_r;
        end else if (can_alloc) begin
          nkey_we  = 1'b1;
          nval_we  = 1'b1;
          nnext_we = 1'b1;
          do_alloc = 1'b1;
        end
      end else if (op_r == chtab_pkg::OP_REMOVE && hit_r) begin
        do_free = (stored_r != '0);
        if (prev_r == NIL) begin
          head_we = 1'b1;
          head_wd = nn_q_r;
        end else begin
          nnext_we = 1'b1;
          nnext_wa = prev_r;
          nnext_wd = nn_q_r;
        end
      end
    end else if (cmd.link) begin
      if (tail_r == NIL) begin
        head_we = 1'b1;
      end else begin
        nnext_we = 1'b1;
        nnext_wa = tail_r;
        nnext_wd = fresh_r;
      end
    end
  end

  // result
  logic [1:0] st_r;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      st_r <= chtab_pkg::ST_OK;
    end else if (cmd.act) begin
      case (op_r)
        chtab_pkg::OP_PUT:
          st_r <= (!hit_r && !can_alloc) ? chtab_pkg::ST_FULL : chtab_pkg::ST_OK;
        chtab_pkg::OP_GET, chtab_pkg::OP_REMOVE, chtab_pkg::OP_EXISTS:
          st_r <= hit_r ? chtab_pkg::ST_OK : chtab_pkg::ST_NOKEY;
        default: st_r <= chtab_pkg::ST_OK;
      endcase
    end
  end

  logic        out_valid_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_found_r;
  logic [8:0]  out_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.finish;
    if (cmd.finish) begin
      out_status_r <= st_r;
      out_found_r  <= 32'(found_r);
      out_count_r  <= 9'(stored_r);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_found_r;
  assign out_entry_count = out_count_r;

  assign sts.div_done  = (div_cnt_r == KCW'(KEY_BITS));
  assign sts.walk_end  = (cur_r >= NIL) || (steps_r == NIL);
  assign sts.key_match = key_match;
  assign sts.hit       = hit_r;
  assign sts.can_alloc = can_alloc;
  assign sts.op        = op_r;

`ifndef SYNTHESIS
  a_stored_range: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r <= NIL) else $error("stored count above pool size");
  a_mark_covers: assert property (@(posedge clk) disable iff (!rst_n)
    hw_r >= stored_r) else $error("free stack mark below stored count");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |-> rem_r < n_r) else $error("remainder not below divisor");
  a_one_update: assert property (@(posedge clk) disable iff (!rst_n)
    !(do_alloc && do_free)) else $error("alloc and free in one cycle");
`endif

endmodule

### rtl/chained_hash_key_value_table.sv
// Chained hash key/value table: put, get, remove, exists, clear on a fixed node pool.
// Clear and unused op codes go straight to the result; other ops run the bit-serial modulo,
//   the head read, a node read and key compare per node checked, the update and, for put of a
//   new key, a link into its chain, then the result.
// One request in flight; the next is accepted in the cycle in which out_valid is high.
// Reset (synchronous, rst_n low): buckets empty, pool free, count zero, bucket_count 64.
module chained_hash_key_value_table #(
  parameter int NUM_BUCKETS = 64,
  parameter int POOL_SIZE   = 256,
  parameter int KEY_BITS    = 32,
  parameter int VALUE_BITS  = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [31:0] in_key,
  input  logic [31:0] in_value,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [31:0] out_found_value,
  output logic [8:0]  out_entry_count,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata
);

  chtab_pkg::cmd_t cmd;
  chtab_pkg::sts_t sts;

  chtab_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  chtab_dp #(
    .NUM_BUCKETS (NUM_BUCKETS),
    .POOL_SIZE   (POOL_SIZE),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_key          (in_key),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

endmodule
